// ===== src/clf_pkg.sv =====
`default_nettype none

package clf_pkg;

   // Sizing defaults for the frame store
   localparam int MAX_ROWS_DEFAULT    = 4;
   localparam int MAX_COLUMNS_DEFAULT = 20;

   // Field and register widths
   localparam int CMD_W       = 3;
   localparam int ROW_W       = 3;
   localparam int COL_W       = 5;
   localparam int POS_W       = 8;
   localparam int BYTE_W      = 8;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 5;
   localparam int GLYPH_BYTES = 8;
   localparam int GLYPH_CNT_W = 3;
   localparam int DIV_CNT_W   = 4;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SET_CURSOR = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PUT_CHAR   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_REFRESH    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_LOAD_GLYPH = 3'd4;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMN_COUNT = 1'b1;

   localparam logic [ROW_W-1:0] ROW_COUNT_RESET    = 3'd2;
   localparam logic [COL_W-1:0] COLUMN_COUNT_RESET = 5'd16;

   // Bus bytes
   localparam logic [BYTE_W-1:0] DDRAM_CMD    = 8'h80;
   localparam logic [BYTE_W-1:0] LINE1_OFFSET = 8'h40;
   localparam logic [BYTE_W-1:0] CGRAM_CMD    = 8'h40;
   localparam logic [2:0]        SLOT_MASK    = 3'h7;
   localparam logic [BYTE_W-1:0] SPACE_CHAR   = 8'h20;
   localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'h0A;

   typedef struct packed {
      logic [CMD_W-1:0]           command;
      logic [5:0]                 column;
      logic [ROW_W-1:0]           row;
      logic [BYTE_W-1:0]          char_code;
      logic                       line_select;
      logic [2:0]                 glyph_slot;
      logic [GLYPH_BYTES*8-1:0]   glyph_rows;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] lcd_byte;
      logic              is_data;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic [POS_W-1:0] dividend;
      logic [COL_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [POS_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_CMD,
      ST_READ,
      ST_DATA,
      ST_GLYPH
   } state_type;

endpackage

`default_nettype wire

// ===== src/clf_ram.sv =====
`default_nettype none

module clf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 80,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== src/clf_divider.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module clf_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire clf_pkg::div_req_type div_req,
   output clf_pkg::div_rsp_type      div_rsp
);

   localparam int PW = clf_pkg::POS_W;
   localparam int CW = clf_pkg::COL_W;

   logic [clf_pkg::DIV_CNT_W-1:0] count_ff, count_in;
   logic                          done_ff, done_in;
   logic [PW-1:0]                 q_ff, q_in;
   logic [CW-1:0]                 rem_ff, rem_in;
   logic [CW-1:0]                 divisor_ff, divisor_in;
   logic [CW+1:0]                 trial;

   assign trial = {1'b0, rem_ff, q_ff[PW-1]} - {2'b00, divisor_ff};

   always_comb begin
      count_in   = count_ff;
      done_in    = 1'b0;
      q_in       = q_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         count_in   = clf_pkg::DIV_CNT_W'(PW);
         q_in       = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == clf_pkg::DIV_CNT_W'(1));
         q_in     = {q_ff[PW-2:0], ~trial[CW+1]};
         // remainder stays below the divisor, so the top bit is always clear
         rem_in   = trial[CW+1] ? {rem_ff[CW-2:0], q_ff[PW-1]} : trial[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      q_ff       <= q_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = q_ff;

endmodule

`default_nettype wire

// ===== src/char_lcd_frame_refresh.sv =====
`default_nettype none

// Channel   Ports                               Moves
// -------   ---------------------------------   -------------------------------
// request   req_valid / req_ready / req_data    one command item in
// response  rsp_valid / rsp_ready / rsp_data    one LCD bus byte item out
// config    csr_write_enable / csr_index / csr_data   row and column count writes
//
// Clear, set cursor and plain put char complete in the idle state; a newline
// runs the 8-step divider between issue and finish. Refresh line starts, then
// sends the command byte and, per row byte, a frame store read, then the output
// register; a line has up to 40 row bytes. Load glyph sends the command byte, then 8.
// Per-entry valid bits make the store read as spaces after reset.
// A stalled rsp_ready holds the sequencer on its current byte.
module char_lcd_frame_refresh #(
   parameter int MAX_ROWS    = clf_pkg::MAX_ROWS_DEFAULT,
   parameter int MAX_COLUMNS = clf_pkg::MAX_COLUMNS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_enable,
   input  wire logic [clf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [clf_pkg::CSR_DATA_W-1:0]   csr_data,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire clf_pkg::req_type                 req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output clf_pkg::rsp_type                      rsp_data
);

   localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int RW     = clf_pkg::ROW_W;
   localparam int CW     = clf_pkg::COL_W;
   localparam int PW     = clf_pkg::POS_W;
   localparam int BW     = clf_pkg::BYTE_W;
   localparam int NP_W   = PW + CW;        // (quotient + 1) * columns
   localparam int MUL_W  = 2 + CW;         // row index times columns

   // configuration
   logic [RW-1:0] row_count_ff;
   logic [CW-1:0] column_count_ff;
   logic [RW-1:0] rows_eff;
   logic [CW-1:0] cols_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= clf_pkg::ROW_COUNT_RESET;
         column_count_ff <= clf_pkg::COLUMN_COUNT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            clf_pkg::CSR_ROW_COUNT:    row_count_ff    <= csr_data[RW-1:0];
            clf_pkg::CSR_COLUMN_COUNT: column_count_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // clamp to 1..max before any use
   always_comb begin
      rows_eff = row_count_ff;
      if (row_count_ff == '0) rows_eff = RW'(1);
      else if (row_count_ff > RW'(MAX_ROWS)) rows_eff = RW'(MAX_ROWS);
      cols_eff = column_count_ff;
      if (column_count_ff == '0) cols_eff = CW'(1);
      else if (column_count_ff > CW'(MAX_COLUMNS)) cols_eff = CW'(MAX_COLUMNS);
   end

   // sequencer state
   clf_pkg::state_type      state_ff, state_in;
   logic [PW-1:0]           cursor_ff, cursor_in;
   logic                    stopped_ff, stopped_in;
   logic [BW-1:0]           cmd_byte_ff, cmd_byte_in;
   logic                    glyph_ff, glyph_in;
   logic [1:0]              row_ff, row_in;
   logic [CW-1:0]           col_ff, col_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic [clf_pkg::GLYPH_BYTES*8-1:0] shift_ff, shift_in;
   logic [clf_pkg::GLYPH_CNT_W-1:0]   gcount_ff, gcount_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   clf_pkg::rsp_type        rsp_data_ff, rsp_data_in;
   logic                    out_free;
   logic                    load_rsp;
   clf_pkg::rsp_type        load_value;

   // frame store
   logic                    valid_ff [DEPTH];
   logic                    rd_valid_ff;
   logic                    clear_store;
   logic                    ram_we, ram_re;
   logic [BW-1:0]           ram_rdata;
   logic [BW-1:0]           store_byte;

   // divider
   clf_pkg::div_req_type    div_req;
   clf_pkg::div_rsp_type    div_rsp;

   // arithmetic
   logic [PW-1:0]           limit;
   logic [PW-1:0]           set_pos;
   logic [NP_W-1:0]         np;
   logic [PW-1:0]           np_sat;
   logic [1:0]              next_row;
   logic                    second_row;
   logic                    col_last;
   logic [ADDR_W-1:0]       next_base;
   logic [MUL_W-1:0]        base_mul;

   assign limit   = {{(PW-RW){1'b0}}, rows_eff} * {{(PW-CW){1'b0}}, cols_eff};
   assign set_pos = {2'b00, req_data.column}
                  + ({{(PW-RW){1'b0}}, req_data.row} * {{(PW-CW){1'b0}}, cols_eff});
   assign np      = ({{CW{1'b0}}, div_rsp.quotient} + NP_W'(1))
                  * {{PW{1'b0}}, cols_eff};
   assign np_sat  = (np > NP_W'(255)) ? {PW{1'b1}} : np[PW-1:0];

   // rows 2 and 3 follow rows 0 and 1 on the same controller line
   assign next_row   = row_ff + 2'd2;
   assign second_row = !row_ff[1] && ({1'b0, row_ff} + 3'd3 <= rows_eff);
   assign col_last   = (col_ff == cols_eff - 1'b1);
   assign base_mul   = {{CW{1'b0}}, next_row} * {2'b00, cols_eff};
   assign next_base  = ADDR_W'(base_mul);

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign store_byte = rd_valid_ff ? ram_rdata : clf_pkg::SPACE_CHAR;
   assign req_ready  = (state_ff == clf_pkg::ST_IDLE);

   always_comb begin
      state_in         = state_ff;
      cursor_in        = cursor_ff;
      stopped_in       = stopped_ff;
      cmd_byte_in      = cmd_byte_ff;
      glyph_in         = glyph_ff;
      row_in           = row_ff;
      col_in           = col_ff;
      addr_in          = addr_ff;
      shift_in         = shift_ff;
      gcount_in        = gcount_ff;
      load_rsp         = 1'b0;
      load_value       = '0;
      clear_store      = 1'b0;
      ram_we           = 1'b0;
      ram_re           = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = cursor_ff;
      div_req.divisor  = cols_eff;

      case (state_ff)
         clf_pkg::ST_IDLE: begin
            col_in = '0;
            if (req_valid) begin
               case (req_data.command)
                  clf_pkg::CMD_CLEAR: begin
                     clear_store = 1'b1;
                  end
                  clf_pkg::CMD_SET_CURSOR: begin
                     cursor_in  = set_pos;
                     stopped_in = 1'b0;
                  end
                  clf_pkg::CMD_PUT_CHAR: begin
                     if (!stopped_ff) begin
                        if (req_data.char_code == clf_pkg::NEWLINE_CHAR) begin
                           div_req.start = 1'b1;
                           state_in      = clf_pkg::ST_DIVIDE;
                        end else if (cursor_ff >= limit) begin
                           stopped_in = 1'b1;
                        end else begin
                           ram_we    = 1'b1;
                           cursor_in = cursor_ff + 1'b1;
                        end
                     end
                  end
                  clf_pkg::CMD_REFRESH: begin
                     glyph_in = 1'b0;
                     if (!req_data.line_select) begin
                        cmd_byte_in = clf_pkg::DDRAM_CMD;
                        row_in      = 2'd0;
                        addr_in     = '0;
                        state_in    = clf_pkg::ST_CMD;
                     end else if (rows_eff >= RW'(2)) begin
                        // line 1 exists only with two or more rows
                        cmd_byte_in = clf_pkg::DDRAM_CMD | clf_pkg::LINE1_OFFSET;
                        row_in      = 2'd1;
                        addr_in     = ADDR_W'(cols_eff);
                        state_in    = clf_pkg::ST_CMD;
                     end
                  end
                  clf_pkg::CMD_LOAD_GLYPH: begin
                     glyph_in    = 1'b1;
                     cmd_byte_in = clf_pkg::CGRAM_CMD
                                 | {2'b00, req_data.glyph_slot & clf_pkg::SLOT_MASK, 3'b000};
                     shift_in    = req_data.glyph_rows;
                     gcount_in   = '0;
                     state_in    = clf_pkg::ST_CMD;
                  end
                  default: ;
               endcase
            end
         end

         clf_pkg::ST_DIVIDE: begin
            if (div_rsp.done) begin
               cursor_in = np_sat;
               state_in  = clf_pkg::ST_IDLE;
            end
         end

         clf_pkg::ST_CMD: begin
            if (out_free) begin
               load_rsp            = 1'b1;
               load_value.lcd_byte = cmd_byte_ff;
               load_value.is_data  = 1'b0;
               load_value.last     = 1'b0;
               state_in = glyph_ff ? clf_pkg::ST_GLYPH : clf_pkg::ST_READ;
            end
         end

         clf_pkg::ST_READ: begin
            ram_re   = 1'b1;
            state_in = clf_pkg::ST_DATA;
         end

         clf_pkg::ST_DATA: begin
            if (out_free) begin
               load_rsp            = 1'b1;
               load_value.lcd_byte = store_byte;
               load_value.is_data  = 1'b1;
               load_value.last     = col_last && !second_row;
               if (col_last) begin
                  if (second_row) begin
                     row_in   = next_row;
                     col_in   = '0;
                     addr_in  = next_base;
                     state_in = clf_pkg::ST_READ;
                  end else begin
                     state_in = clf_pkg::ST_IDLE;
                  end
               end else begin
                  col_in   = col_ff + 1'b1;
                  addr_in  = addr_ff + 1'b1;
                  state_in = clf_pkg::ST_READ;
               end
            end
         end

         clf_pkg::ST_GLYPH: begin
            if (out_free) begin
               load_rsp            = 1'b1;
               load_value.lcd_byte = shift_ff[7:0];
               load_value.is_data  = 1'b1;
               load_value.last     =
                  (gcount_ff == clf_pkg::GLYPH_CNT_W'(clf_pkg::GLYPH_BYTES - 1));
               shift_in  = shift_ff >> 8;
               gcount_in = gcount_ff + 1'b1;
               if (load_value.last) begin
                  state_in = clf_pkg::ST_IDLE;
               end
            end
         end

         default: begin
            state_in = clf_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = load_value;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= clf_pkg::ST_IDLE;
         cursor_ff    <= '0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         stopped_ff   <= stopped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_byte_ff <= cmd_byte_in;
      glyph_ff    <= glyph_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      addr_ff     <= addr_in;
      shift_ff    <= shift_in;
      gcount_ff   <= gcount_in;
      rsp_data_ff <= rsp_data_in;
   end

   // valid bits: a cleared entry reads as a space
   always_ff @(posedge clock) begin
      if (reset || clear_store) begin
         for (int i = 0; i < DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (ram_we) begin
         valid_ff[cursor_ff[ADDR_W-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_re) begin
         rd_valid_ff <= valid_ff[addr_ff];
      end
   end

   clf_ram #(
      .WIDTH (BW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (cursor_ff[ADDR_W-1:0]),
      .wdata (req_data.char_code),
      .re    (ram_re),
      .raddr (addr_ff),
      .rdata (ram_rdata)
   );

   clf_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== tb/char_lcd_frame_refresh_checker.sv =====
`timescale 1ns / 1ps

// Watches the request, response and register ports, keeps its own copy of the
// frame store and cursor, and compares every bus byte against the oldest due one.
module char_lcd_frame_refresh_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_enable,
   input  wire logic [clf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [clf_pkg::CSR_DATA_W-1:0]   csr_data,
   input  wire logic                             req_valid,
   input  wire logic                             req_ready,
   input  wire clf_pkg::req_type                 req_data,
   input  wire logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   input  wire clf_pkg::rsp_type                 rsp_data,
   output int unsigned                           due_count,
   output int unsigned                           error_count
);

   localparam int STORE_DEPTH = clf_pkg::MAX_ROWS_DEFAULT * clf_pkg::MAX_COLUMNS_DEFAULT;

   logic [clf_pkg::BYTE_W-1:0] frame_copy [STORE_DEPTH];
   logic [clf_pkg::POS_W-1:0]  cursor_copy;
   logic                       stopped_copy;
   logic [clf_pkg::ROW_W-1:0]  row_setting;
   logic [clf_pkg::COL_W-1:0]  col_setting;
   clf_pkg::rsp_type           bus_bytes_due [$];
   clf_pkg::rsp_type           oldest_due;

   function automatic int unsigned clamp(input int unsigned v, input int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic clear_frame();
      foreach (frame_copy[i]) frame_copy[i] = clf_pkg::SPACE_CHAR;
   endtask

   // Updates the copy for one accepted item and queues the bus bytes it causes.
   task automatic predict_bus_bytes(input clf_pkg::req_type item);
      int unsigned      rows;
      int unsigned      cols;
      int unsigned      pos;
      int               r;
      int               c;
      clf_pkg::rsp_type run [$];
      clf_pkg::rsp_type b;
      rows = clamp(row_setting, clf_pkg::MAX_ROWS_DEFAULT);
      cols = clamp(col_setting, clf_pkg::MAX_COLUMNS_DEFAULT);
      b = '0;
      case (item.command)
         clf_pkg::CMD_CLEAR: begin
            clear_frame();
         end
         clf_pkg::CMD_SET_CURSOR: begin
            cursor_copy  = clf_pkg::POS_W'(item.column + item.row * cols);
            stopped_copy = 1'b0;
         end
         clf_pkg::CMD_PUT_CHAR: begin
            if (!stopped_copy) begin
               if (item.char_code == clf_pkg::NEWLINE_CHAR) begin
                  pos = (cursor_copy / cols + 1) * cols;
                  cursor_copy = (pos > 255) ? 8'hFF : clf_pkg::POS_W'(pos);
               end else if (cursor_copy >= rows * cols) begin
                  stopped_copy = 1'b1;
               end else begin
                  frame_copy[cursor_copy] = item.char_code;
                  cursor_copy = cursor_copy + 1'b1;
               end
            end
         end
         clf_pkg::CMD_REFRESH: begin
            // line 0 carries rows 0 and 2, line 1 rows 1 and 3
            if (item.line_select < rows) begin
               b.lcd_byte = clf_pkg::DDRAM_CMD
                          | (item.line_select ? clf_pkg::LINE1_OFFSET : 8'h00);
               b.is_data  = 1'b0;
               run.push_back(b);
               b.is_data = 1'b1;
               for (r = item.line_select; r < rows; r += 2) begin
                  for (c = 0; c < cols; c++) begin
                     pos = r * cols + c;
                     b.lcd_byte = (pos < STORE_DEPTH) ? frame_copy[pos]
                                                      : clf_pkg::SPACE_CHAR;
                     run.push_back(b);
                  end
               end
            end
         end
         clf_pkg::CMD_LOAD_GLYPH: begin
            b.lcd_byte = clf_pkg::CGRAM_CMD
                       | {2'b00, item.glyph_slot & clf_pkg::SLOT_MASK, 3'b000};
            b.is_data  = 1'b0;
            run.push_back(b);
            b.is_data = 1'b1;
            for (r = 0; r < clf_pkg::GLYPH_BYTES; r++) begin
               b.lcd_byte = item.glyph_rows[8*r +: 8];
               run.push_back(b);
            end
         end
         default: ;
      endcase
      if (run.size() > 0) begin
         b = run.pop_back();
         b.last = 1'b1;
         run.push_back(b);
      end
      foreach (run[i]) bus_bytes_due.push_back(run[i]);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_frame();
         cursor_copy  = '0;
         stopped_copy = 1'b0;
         row_setting  = clf_pkg::ROW_COUNT_RESET;
         col_setting  = clf_pkg::COLUMN_COUNT_RESET;
         bus_bytes_due.delete();
         error_count  = 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == clf_pkg::CSR_ROW_COUNT) begin
               row_setting = csr_data[clf_pkg::ROW_W-1:0];
            end else if (csr_index == clf_pkg::CSR_COLUMN_COUNT) begin
               col_setting = csr_data[clf_pkg::COL_W-1:0];
            end
         end
         // results leave before the new item's are queued; none come in the same cycle
         if (rsp_valid && rsp_ready) begin
            if (bus_bytes_due.size() == 0) begin
               $display("%0t: unexpected bus byte: expected none,", $time);
               $display("%0t:   actual byte %02h data %0b last %0b",
                        $time, rsp_data.lcd_byte, rsp_data.is_data, rsp_data.last);
               error_count++;
            end else begin
               oldest_due = bus_bytes_due.pop_front();
               if (rsp_data !== oldest_due) begin
                  $display("%0t: bus byte mismatch: expected byte %02h data %0b last %0b,",
                           $time, oldest_due.lcd_byte, oldest_due.is_data, oldest_due.last);
                  $display("%0t:   actual byte %02h data %0b last %0b",
                           $time, rsp_data.lcd_byte, rsp_data.is_data, rsp_data.last);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) predict_bus_bytes(req_data);
      end
      due_count <= bus_bytes_due.size();
   end

endmodule

// ===== tb/char_lcd_frame_refresh_tb.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the character LCD frame refresh block. The checker
// beside the block does all prediction and comparison; this module only makes
// items, register writes and backpressure.
module char_lcd_frame_refresh_tb;

   // generous: every refresh at 41 bytes under heavy stalls fits many times over
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_ITEMS = 35;
   // newline runs through the divider with no result, so idle this long before writes
   localparam int SETTLE_CYCLES = 60;

   logic                            clock            = 1'b0;
   logic                            reset            = 1'b1;
   logic                            csr_write_enable = 1'b0;
   logic [clf_pkg::CSR_INDEX_W-1:0] csr_index        = '0;
   logic [clf_pkg::CSR_DATA_W-1:0]  csr_data         = '0;
   logic                            req_valid        = 1'b0;
   logic                            req_ready;
   clf_pkg::req_type                req_data         = '0;
   logic                            rsp_valid;
   logic                            rsp_ready        = 1'b0;
   clf_pkg::rsp_type                rsp_data;

   int unsigned due_count;
   int unsigned error_count;
   int unsigned cycle_count = 0;

   // when set, neither side idles
   logic steady_flow = 1'b0;

   // effective geometry as the block sees it, for well-formed cursor moves
   int unsigned cur_rows = 2;
   int unsigned cur_cols = 16;

   // raw register values per phase; includes both extremes and out-of-range
   // values on either side of the legal span (bits 3 and 4 on the row write too)
   int unsigned phase_rows [8] = '{1, 4, 4, 0, 28, 3, 5, 2};
   int unsigned phase_cols [8] = '{20, 20, 1, 0, 31, 8, 21, 16};

   char_lcd_frame_refresh i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data)
   );

   char_lcd_frame_refresh_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .due_count        (due_count),
      .error_count      (error_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Receiver stalls about a third of the time, except during the steady stretch.
   always @(posedge clock) begin
      rsp_ready <= steady_flow || ($urandom_range(99) >= 34);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("char_lcd_frame_refresh_tb: errors");
         $finish;
      end
   end

   function automatic int unsigned clamp(input int unsigned v, input int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // Every field gets random content, so unused fields toggle all their bits.
   function automatic clf_pkg::req_type scrambled_item(input logic [clf_pkg::CMD_W-1:0] cmd);
      clf_pkg::req_type item;
      item.command     = cmd;
      item.column      = 6'($urandom);
      item.row         = 3'($urandom);
      item.char_code   = 8'($urandom);
      item.line_select = 1'($urandom);
      item.glyph_slot  = 3'($urandom);
      item.glyph_rows  = {$urandom, $urandom};
      return item;
   endfunction

   function automatic clf_pkg::req_type cursor_item(input int unsigned col,
                                                    input int unsigned row);
      clf_pkg::req_type item;
      item        = scrambled_item(clf_pkg::CMD_SET_CURSOR);
      item.column = 6'(col);
      item.row    = 3'(row);
      return item;
   endfunction

   function automatic clf_pkg::req_type char_item(input logic [clf_pkg::BYTE_W-1:0] ch);
      clf_pkg::req_type item;
      item           = scrambled_item(clf_pkg::CMD_PUT_CHAR);
      item.char_code = ch;
      return item;
   endfunction

   function automatic clf_pkg::req_type refresh_item(input logic line);
      clf_pkg::req_type item;
      item             = scrambled_item(clf_pkg::CMD_REFRESH);
      item.line_select = line;
      return item;
   endfunction

   function automatic clf_pkg::req_type glyph_item(input logic [2:0] slot,
                                                   input logic [63:0] bits);
      clf_pkg::req_type item;
      item            = scrambled_item(clf_pkg::CMD_LOAD_GLYPH);
      item.glyph_slot = slot;
      item.glyph_rows = bits;
      return item;
   endfunction

   // One item: optional idle gap, then valid held until the handshake.
   // Sampled at the edge, so req_ready is the value the block saw.
   task automatic send(input clf_pkg::req_type item);
      while (!steady_flow && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid, wait for the last due byte, then let a silent newline finish.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Both registers in back-to-back cycles; enable stays high across them.
   task automatic write_geometry(input int unsigned rows_raw, input int unsigned cols_raw);
      csr_write_enable <= 1'b1;
      csr_index        <= clf_pkg::CSR_ROW_COUNT;
      csr_data         <= clf_pkg::CSR_DATA_W'(rows_raw);
      @(posedge clock);
      csr_index        <= clf_pkg::CSR_COLUMN_COUNT;
      csr_data         <= clf_pkg::CSR_DATA_W'(cols_raw);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_rows = clamp(rows_raw & 32'h7, clf_pkg::MAX_ROWS_DEFAULT);
      cur_cols = clamp(cols_raw & 32'h1F, clf_pkg::MAX_COLUMNS_DEFAULT);
   endtask

   // Mostly printable text, with newlines and the odd raw byte mixed in.
   function automatic logic [clf_pkg::BYTE_W-1:0] text_char();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 12) return clf_pkg::NEWLINE_CHAR;
      if (pick < 20) return 8'($urandom);
      return 8'($urandom_range(8'h7E, 8'h21));
   endfunction

   // Single item of any kind, mostly the rarer commands and malformed moves.
   task automatic send_noise();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 30)      send(scrambled_item(clf_pkg::CMD_LOAD_GLYPH));
      else if (pick < 50) send(scrambled_item(clf_pkg::CMD_REFRESH));
      else if (pick < 60) send(scrambled_item(clf_pkg::CMD_CLEAR));
      else if (pick < 75) send(scrambled_item(clf_pkg::CMD_SET_CURSOR));
      else if (pick < 90) send(scrambled_item(clf_pkg::CMD_PUT_CHAR));
      else                send(scrambled_item(clf_pkg::CMD_W'($urandom_range(7, 5))));
   endtask

   // Mostly cursor, text, refresh sequences; text may run past the end of the
   // display, which stops writing until the next cursor move.
   task automatic run_phase(input int unsigned items);
      int unsigned sent;
      int unsigned len;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(99) < 65) begin
            send(cursor_item($urandom_range(cur_cols - 1, 0), $urandom_range(cur_rows - 1, 0)));
            len = $urandom_range(cur_cols + 4, 1);
            repeat (len) send(char_item(text_char()));
            send(refresh_item(1'($urandom)));
            sent += len + 2;
         end else begin
            send_noise();
            sent++;
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset geometry, two rows of 16.
      // Store reads as spaces after reset on both lines.
      send(refresh_item(1'b0));
      send(refresh_item(1'b1));
      // byte extremes and a newline into the second row
      send(cursor_item(0, 0));
      send(char_item(8'h00));
      send(char_item(8'hFF));
      send(char_item(8'h41));
      send(char_item(clf_pkg::NEWLINE_CHAR));
      send(char_item(8'h5A));
      send(refresh_item(1'b0));
      send(refresh_item(1'b1));
      // glyph slots and bitmap extremes
      send(glyph_item(3'd7, 64'hFFFF_FFFF_FFFF_FFFF));
      send(glyph_item(3'd0, 64'h0123_4567_89AB_CDEF));
      // last cell written, then a put past the end stops writing; newline and
      // further puts are ignored until the next cursor move
      send(cursor_item(15, 1));
      send(char_item(8'h78));
      send(char_item(8'h79));
      send(char_item(clf_pkg::NEWLINE_CHAR));
      send(char_item(8'h71));
      send(refresh_item(1'b1));
      // cursor far out of range, newlines saturate the position at its top
      send(cursor_item(63, 7));
      repeat (7) send(char_item(clf_pkg::NEWLINE_CHAR));
      send(char_item(8'h33));
      // clear keeps the cursor state but blanks the store
      send(scrambled_item(clf_pkg::CMD_CLEAR));
      send(refresh_item(1'b0));
      // unused command codes do nothing
      send(scrambled_item(clf_pkg::CMD_W'(5)));
      send(scrambled_item(clf_pkg::CMD_W'(6)));
      send(scrambled_item(clf_pkg::CMD_W'(7)));

      // Random part, one geometry per phase; phase 5 runs without any idling.
      for (int p = 0; p < 8; p++) begin
         settle();
         write_geometry(phase_rows[p], phase_cols[p]);
         steady_flow <= (p == 5);
         run_phase(PHASE_ITEMS);
      end

      // Drain, then leave room for a trailing silent item.
      req_valid <= 1'b0;
      steady_flow <= 1'b0;
      @(posedge clock);
      while (due_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("char_lcd_frame_refresh_tb: clean");
      end else begin
         $display("char_lcd_frame_refresh_tb: errors");
      end
      $finish;
   end

endmodule
